// ===== rtl/dssnp_pkg.sv =====
// Shared constants, codes and types of the SDT service name parser.
`default_nettype none

package dssnp_pkg;

    // Section and descriptor identifiers.
    localparam logic [7:0] TABLE_ID_SDT = 8'h42;
    localparam logic [7:0] TAG_SERVICE  = 8'h48;

    // Service loop geometry.
    localparam int LOOP_OVERHEAD    = 12;
    localparam int ENTRY_HDR_BYTES  = 5;
    localparam int FIRST_LOOP_BYTE  = 10;

    // Limits on the count of services and on the emitted name length.
    localparam int MAX_SERVICES = 128;
    localparam int NAME_MAX     = 32;

    // Result kinds.
    localparam logic [2:0] KIND_NAME     = 3'd0;
    localparam logic [2:0] KIND_ENTRY    = 3'd1;
    localparam logic [2:0] KIND_ACCEPTED = 3'd2;
    localparam logic [2:0] KIND_REJECTED = 3'd3;
    localparam logic [2:0] KIND_IGNORED  = 3'd4;

    // Configuration register indices, taken from paddr[2].
    localparam logic REG_TS_ID   = 1'b0;
    localparam logic REG_VERSION = 1'b1;

    localparam logic [5:0] VERSION_NONE = 6'd32;

    typedef struct packed {
        logic [15:0] expected_ts_id;
        logic [5:0]  known_version;
    } cfg_t;

    // Every result that one section byte causes, in delivery order:
    // name byte, entry done, section status.
    typedef struct packed {
        logic        name_vld;
        logic        entry_vld;
        logic        stat_vld;
        logic [2:0]  stat_kind;
        logic [15:0] service_ident;
        logic [7:0]  name_char;
        logic [4:0]  char_index;
        logic [7:0]  entry_count;
        logic [4:0]  section_version;
    } bundle_t;

endpackage

`default_nettype wire

// ===== rtl/dvb_sdt_service_name_parser.sv =====
// Top level of the DVB SDT service name parser.
// A section byte is registered in the input register at its transfer and parsed once the
// result register can take its results, which are then held in the result register.
// Throughput: one byte per cycle while m_ready is high; a byte causing k results (at most
// three) holds the single result register and the input register for k output transfers.
// Reset (aresetn low at a clock edge) clears the parser, pending results and registers.
`default_nettype none

module dvb_sdt_service_name_parser #(
    parameter int MAX_SERVICES = dssnp_pkg::MAX_SERVICES,
    parameter int NAME_MAX     = dssnp_pkg::NAME_MAX
) (
    input  wire         aclk,
    input  wire         aresetn,
    // Configuration port.
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Section bytes in.
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [7:0]  s_data_byte,
    input  wire         s_last_byte,
    // Results out.
    output logic        m_valid,
    input  wire         m_ready,
    output logic [2:0]  m_kind,
    output logic [15:0] m_service_ident,
    output logic [7:0]  m_name_char,
    output logic [4:0]  m_char_index,
    output logic [7:0]  m_entry_count,
    output logic [4:0]  m_section_version,
    output logic        m_run_last
);
    import dssnp_pkg::*;

    cfg_t    cfg;
    bundle_t bundle;
    logic    load_we;
    logic    load_ready;

    // Register 0 at byte address 0 holds the expected transport stream id,
    // register 1 at byte address 4 the version already stored (32 meaning none).
    dssnp_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The parser holds one byte in its input register and updates the section
    // state from it, handing every result that the byte causes to the output
    // stage as one bundle.
    dssnp_parser #(
        .MAX_SERVICES (MAX_SERVICES),
        .NAME_MAX     (NAME_MAX)
    ) u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_last_byte (s_last_byte),
        .load_ready  (load_ready),
        .load_we     (load_we),
        .bundle      (bundle)
    );

    // The output stage presents the bundled results in order, name byte first,
    // then entry done, then section status, marking the final one of the byte.
    dssnp_out_stage u_out (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .load_we           (load_we),
        .bundle            (bundle),
        .load_ready        (load_ready),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_kind            (m_kind),
        .m_service_ident   (m_service_ident),
        .m_name_char       (m_name_char),
        .m_char_index      (m_char_index),
        .m_entry_count     (m_entry_count),
        .m_section_version (m_section_version),
        .m_run_last        (m_run_last)
    );

endmodule

`default_nettype wire

// ===== rtl/dssnp_apb_regs.sv =====
// APB configuration registers of the SDT service name parser.
`default_nettype none

module dssnp_apb_regs (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               psel,
    input  wire               penable,
    input  wire               pwrite,
    input  wire  [2:0]        paddr,
    input  wire  [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output dssnp_pkg::cfg_t   cfg
);
    import dssnp_pkg::*;

    cfg_t cfg_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.expected_ts_id <= 16'd0;
            cfg_reg.known_version  <= VERSION_NONE;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_TS_ID:   cfg_reg.expected_ts_id <= pwdata[15:0];
                REG_VERSION: cfg_reg.known_version  <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_TS_ID:   prdata = {16'd0, cfg_reg.expected_ts_id};
            REG_VERSION: prdata = {26'd0, cfg_reg.known_version};
            default:     prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/dssnp_parser.sv =====
// Input register and per-byte section parsing state machine.
`default_nettype none

module dssnp_parser #(
    parameter int MAX_SERVICES = dssnp_pkg::MAX_SERVICES,
    parameter int NAME_MAX     = dssnp_pkg::NAME_MAX
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  dssnp_pkg::cfg_t     cfg,
    input  wire                 s_valid,
    output logic                s_ready,
    input  wire  [7:0]          s_data_byte,
    input  wire                 s_last_byte,
    input  wire                 load_ready,
    output logic                load_we,
    output dssnp_pkg::bundle_t  bundle
);
    import dssnp_pkg::*;

    typedef enum logic [3:0] {
        PH_HDR, PH_ENTRY, PH_TAG, PH_LEN, PH_BODY, PH_STYPE,
        PH_PLEN, PH_PROV, PH_NLEN, PH_NAME, PH_TAIL
    } phase_t;

    typedef enum logic [1:0] {
        ST_OPEN, ST_ACCEPTED, ST_REJECTED, ST_IGNORED
    } status_t;

    logic        in_vld_reg, in_vld_next;
    logic [7:0]  in_data_reg;
    logic        in_last_reg;
    logic        process;

    phase_t      phase_reg, phase_next;
    status_t     status_reg, status_next;
    logic [11:0] pos_reg, pos_next;
    logic [11:0] sec_len_reg, sec_len_next;
    logic [15:0] stream_reg, stream_next;
    logic [4:0]  version_reg, version_next;
    logic [15:0] service_reg, service_next;
    logic [11:0] loop_reg, loop_next;
    logic [7:0]  field_reg, field_next;
    logic [7:0]  name_pos_reg, name_pos_next;
    logic [7:0]  seen_reg, seen_next;
    logic [11:0] descr_reg, descr_next;
    logic [7:0]  desc_reg, desc_next;
    logic        is_svc_reg, is_svc_next;

    logic        name_fire;
    logic        entry_fire;
    logic [7:0]  b;
    logic [2:0]  hdr_idx;
    logic [7:0]  field_dec;
    logic [7:0]  desc_dec;

    assign process = in_vld_reg && load_ready;
    assign s_ready = !in_vld_reg || process;
    assign b       = in_data_reg;

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_valid && s_ready) begin
            in_vld_next = 1'b1;
        end else if (process) begin
            in_vld_next = 1'b0;
        end
    end

    always_comb begin
        phase_next    = phase_reg;
        status_next   = status_reg;
        pos_next      = pos_reg;
        sec_len_next  = sec_len_reg;
        stream_next   = stream_reg;
        version_next  = version_reg;
        service_next  = service_reg;
        loop_next     = loop_reg;
        field_next    = field_reg;
        name_pos_next = name_pos_reg;
        seen_next     = seen_reg;
        descr_next    = descr_reg;
        desc_next     = desc_reg;
        is_svc_next   = is_svc_reg;
        name_fire     = 1'b0;
        entry_fire    = 1'b0;
        hdr_idx       = 3'(3'(ENTRY_HDR_BYTES) - field_reg[2:0]);
        field_dec     = (field_reg != 8'd0) ? field_reg - 8'd1 : field_reg;
        desc_dec      = desc_reg - 8'd1;

        unique case (phase_reg) inside
            PH_HDR: begin
                case (pos_reg)
                    12'd0: begin
                        seen_next    = 8'd0;
                        service_next = 16'd0;
                        version_next = 5'd0;
                        status_next  = ST_OPEN;
                        if (b != TABLE_ID_SDT) begin
                            status_next = ST_IGNORED;
                            phase_next  = PH_TAIL;
                        end
                    end
                    12'd1: sec_len_next = {b[3:0], 8'h00};
                    12'd2: sec_len_next = sec_len_reg | {4'h0, b};
                    12'd3: stream_next  = {b, 8'h00};
                    12'd4: stream_next  = stream_reg | {8'h00, b};
                    12'd5: begin
                        version_next = b[5:1];
                        if (stream_reg != cfg.expected_ts_id ||
                            {1'b0, b[5:1]} == cfg.known_version) begin
                            status_next = ST_REJECTED;
                            phase_next  = PH_TAIL;
                        end else begin
                            status_next = ST_ACCEPTED;
                            loop_next   = (sec_len_reg >= 12'(LOOP_OVERHEAD)) ?
                                          12'(sec_len_reg - 12'(LOOP_OVERHEAD)) : 12'd0;
                        end
                    end
                    default: begin
                        if (pos_reg >= 12'(FIRST_LOOP_BYTE)) begin
                            if (loop_reg != 12'd0) begin
                                phase_next = PH_ENTRY;
                                field_next = 8'(ENTRY_HDR_BYTES);
                            end else begin
                                phase_next = PH_TAIL;
                            end
                        end
                    end
                endcase
                if (pos_reg != 12'hfff) begin
                    pos_next = pos_reg + 12'd1;
                end
            end

            PH_ENTRY: begin
                loop_next = loop_reg - 12'd1;
                case (hdr_idx)
                    3'd0: begin
                        service_next = {b, 8'h00};
                        if (seen_reg < 8'(MAX_SERVICES)) begin
                            seen_next = seen_reg + 8'd1;
                        end
                    end
                    3'd1: service_next = service_reg | {8'h00, b};
                    3'd3: descr_next   = {b[3:0], 8'h00};
                    3'd4: descr_next   = descr_reg | {4'h0, b};
                    default: ;
                endcase
                field_next = field_dec;
                if (field_dec == 8'd0) begin
                    if (descr_next == 12'd0 || loop_next == 12'd0) begin
                        entry_fire = 1'b1;
                    end else begin
                        phase_next = PH_TAG;
                    end
                end else if (loop_next == 12'd0) begin
                    entry_fire = 1'b1;
                end
            end

            PH_TAG, PH_LEN, PH_BODY, PH_STYPE, PH_PLEN, PH_PROV, PH_NLEN,
            PH_NAME: begin
                loop_next  = loop_reg - 12'd1;
                descr_next = descr_reg - 12'd1;
                if (phase_reg == PH_TAG) begin
                    is_svc_next = (b == TAG_SERVICE);
                    phase_next  = PH_LEN;
                end else if (phase_reg == PH_LEN) begin
                    desc_next = b;
                    if (b == 8'd0) begin
                        phase_next = PH_TAG;
                    end else begin
                        phase_next = is_svc_reg ? PH_STYPE : PH_BODY;
                    end
                end else begin
                    desc_next = desc_dec;
                    case (phase_reg)
                        PH_STYPE: phase_next = PH_PLEN;
                        PH_PLEN: begin
                            field_next = b;
                            phase_next = (b != 8'd0) ? PH_PROV : PH_NLEN;
                        end
                        PH_PROV: begin
                            field_next = field_reg - 8'd1;
                            if (field_reg == 8'd1) begin
                                phase_next = PH_NLEN;
                            end
                        end
                        PH_NLEN: begin
                            field_next    = b;
                            name_pos_next = 8'd0;
                            phase_next    = (b != 8'd0) ? PH_NAME : PH_BODY;
                        end
                        PH_NAME: begin
                            name_fire = (name_pos_reg < 8'(NAME_MAX));
                            if (name_pos_reg != 8'hff) begin
                                name_pos_next = name_pos_reg + 8'd1;
                            end
                            field_next = field_reg - 8'd1;
                            if (field_reg == 8'd1) begin
                                phase_next = PH_BODY;
                            end
                        end
                        default: ;
                    endcase
                    if (desc_dec == 8'd0) begin
                        phase_next = PH_TAG;
                    end
                end
                if (descr_next == 12'd0 || loop_next == 12'd0) begin
                    entry_fire = 1'b1;
                end
            end

            default: ;
        endcase

        // Close the entry: start the next one or drop to the trailing bytes.
        if (entry_fire) begin
            if (loop_next != 12'd0) begin
                phase_next = PH_ENTRY;
                field_next = 8'(ENTRY_HDR_BYTES);
            end else begin
                phase_next = PH_TAIL;
            end
        end

        bundle.name_vld        = name_fire;
        bundle.entry_vld       = entry_fire;
        bundle.stat_vld        = in_last_reg;
        bundle.service_ident   = service_next;
        bundle.name_char       = b;
        bundle.char_index      = name_pos_reg[4:0];
        bundle.entry_count     = seen_next;
        bundle.section_version = version_next;
        case (status_next)
            ST_ACCEPTED: bundle.stat_kind = KIND_ACCEPTED;
            ST_IGNORED:  bundle.stat_kind = KIND_IGNORED;
            default:     bundle.stat_kind = KIND_REJECTED;
        endcase

        if (in_last_reg) begin
            phase_next  = PH_HDR;
            pos_next    = 12'd0;
            status_next = ST_OPEN;
            loop_next   = 12'd0;
        end
    end

    assign load_we = process && (name_fire || entry_fire || in_last_reg);

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data_byte;
            in_last_reg <= s_last_byte;
        end
        if (!aresetn) begin
            in_vld_reg   <= 1'b0;
            phase_reg    <= PH_HDR;
            status_reg   <= ST_OPEN;
            pos_reg      <= 12'd0;
            sec_len_reg  <= 12'd0;
            stream_reg   <= 16'd0;
            version_reg  <= 5'd0;
            service_reg  <= 16'd0;
            loop_reg     <= 12'd0;
            field_reg    <= 8'd0;
            name_pos_reg <= 8'd0;
            seen_reg     <= 8'd0;
            descr_reg    <= 12'd0;
            desc_reg     <= 8'd0;
            is_svc_reg   <= 1'b0;
        end else begin
            in_vld_reg <= in_vld_next;
            if (process) begin
                phase_reg    <= phase_next;
                status_reg   <= status_next;
                pos_reg      <= pos_next;
                sec_len_reg  <= sec_len_next;
                stream_reg   <= stream_next;
                version_reg  <= version_next;
                service_reg  <= service_next;
                loop_reg     <= loop_next;
                field_reg    <= field_next;
                name_pos_reg <= name_pos_next;
                seen_reg     <= seen_next;
                descr_reg    <= descr_next;
                desc_reg     <= desc_next;
                is_svc_reg   <= is_svc_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/dssnp_out_stage.sv =====
// Result register that delivers the results of one byte one transfer at a time.
`default_nettype none

module dssnp_out_stage (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 load_we,
    input  dssnp_pkg::bundle_t  bundle,
    output logic                load_ready,
    output logic                m_valid,
    input  wire                 m_ready,
    output logic [2:0]          m_kind,
    output logic [15:0]         m_service_ident,
    output logic [7:0]          m_name_char,
    output logic [4:0]          m_char_index,
    output logic [7:0]          m_entry_count,
    output logic [4:0]          m_section_version,
    output logic                m_run_last
);
    import dssnp_pkg::*;

    // Pending results: bit 0 name byte, bit 1 entry done, bit 2 status.
    logic [2:0]  pend_reg, pend_next;
    bundle_t     data_reg;
    logic [2:0]  cur_sel;
    logic [2:0]  rest;

    always_comb begin
        if (pend_reg[0]) begin
            cur_sel = 3'b001;
        end else if (pend_reg[1]) begin
            cur_sel = 3'b010;
        end else if (pend_reg[2]) begin
            cur_sel = 3'b100;
        end else begin
            cur_sel = 3'b000;
        end
        rest = pend_reg & ~cur_sel;

        case (cur_sel)
            3'b001:  m_kind = KIND_NAME;
            3'b010:  m_kind = KIND_ENTRY;
            default: m_kind = data_reg.stat_kind;
        endcase

        pend_next = pend_reg;
        if (load_we) begin
            pend_next = {bundle.stat_vld, bundle.entry_vld, bundle.name_vld};
        end else if (m_valid && m_ready) begin
            pend_next = rest;
        end
    end

    assign m_valid           = (pend_reg != 3'b000);
    assign m_run_last        = (rest == 3'b000);
    assign load_ready        = (pend_reg == 3'b000) || (m_ready && rest == 3'b000);
    assign m_service_ident   = data_reg.service_ident;
    assign m_entry_count     = data_reg.entry_count;
    assign m_section_version = data_reg.section_version;
    assign m_name_char       = cur_sel[0] ? data_reg.name_char : 8'd0;
    assign m_char_index      = cur_sel[0] ? data_reg.char_index : 5'd0;

    always_ff @(posedge aclk) begin
        if (load_we) begin
            data_reg <= bundle;
        end
        if (!aresetn) begin
            pend_reg <= 3'b000;
        end else begin
            pend_reg <= pend_next;
        end
    end

endmodule

`default_nettype wire
